// ===== hdl/rbfs_pkg.sv =====
`default_nettype none

package rbfs_pkg;

    localparam int DEPTH       = 256;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int MAX_PATTERN = 4;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int WIN_W       = 8 * MAX_PATTERN;
    localparam int POP_MAX     = 64;
    localparam int CNT_W       = $clog2(POP_MAX + 1);
    localparam int ADDR_W      = 4;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SYNC = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RK_ACK   = 2'd0,
        RK_BYTE  = 2'd1,
        RK_EMPTY = 2'd2,
        RK_SYNC  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SS_FOUND = 2'd0,
        SS_NONE  = 2'd1,
        SS_SHORT = 2'd2
    } t_sync;

    typedef enum logic [1:0] {
        REG_HPAT = 2'd0,
        REG_HLEN = 2'd1,
        REG_TPAT = 2'd2,
        REG_TLEN = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_READ,
        ST_POP_DATA,
        ST_SCAN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [31:0]      hpat;
        logic [LEN_W-1:0] hlen;
        logic [31:0]      tpat;
        logic [LEN_W-1:0] tlen;
    } t_cfg;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [2:0] len);
        logic [LEN_W-1:0] res;
        if (len == 3'd0) begin
            res = LEN_W'(1);
        end else if (int'(len) > MAX_PATTERN) begin
            res = LEN_W'(MAX_PATTERN);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

    // newest byte of the window sits in bits 7..0
    function automatic logic match_win(input logic [WIN_W-1:0] win,
                                       input logic [31:0] pat,
                                       input logic [LEN_W-1:0] len);
        logic                ok;
        logic [WIN_W+31:0]   patx;
        int                  p;
        ok   = 1'b1;
        patx = (WIN_W + 32)'(pat);
        for (int t = 0; t < MAX_PATTERN; t++) begin
            if (t < int'(len)) begin
                p = int'(len) - 1 - t;
                if (win[8*p +: 8] != patx[8*t +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rbfs_if.sv =====
`default_nettype none

interface rbfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       burst_last;
    logic [6:0] pop_limit;

    modport source (output valid, output opcode, output data_byte, output burst_last,
                    output pop_limit, input ready);
    modport sink (input valid, input opcode, input data_byte, input burst_last,
                  input pop_limit, output ready);
endinterface

interface rbfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] byte_out;
    logic [7:0] fill_level;
    logic [1:0] sync_status;
    logic [7:0] frame_start;
    logic [7:0] frame_stop;
    logic       last;

    modport source (output valid, output result_kind, output byte_out, output fill_level,
                    output sync_status, output frame_start, output frame_stop,
                    output last, input ready);
    modport sink (input valid, input result_kind, input byte_out, input fill_level,
                  input sync_status, input frame_start, input frame_stop,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbfs_regs.sv =====
`default_nettype none

module rbfs_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rbfs_pkg::t_cfg             o_cfg
);
    import rbfs_pkg::*;

    logic [31:0] r_hpat;
    logic [2:0]  r_hlen;
    logic [31:0] r_tpat;
    logic [2:0]  r_tlen;
    t_reg        reg_sel;
    logic        wr_en;

    assign reg_sel = t_reg'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpat <= 32'h24;
            r_hlen <= 3'd1;
            r_tpat <= 32'h0a;
            r_tlen <= 3'd1;
        end else if (wr_en) begin
            case (reg_sel)
                REG_HPAT: r_hpat <= pwdata;
                REG_HLEN: r_hlen <= pwdata[2:0];
                REG_TPAT: r_tpat <= pwdata;
                REG_TLEN: r_tlen <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HPAT: prdata = r_hpat;
            REG_HLEN: prdata = 32'(r_hlen);
            REG_TPAT: prdata = r_tpat;
            REG_TLEN: prdata = 32'(r_tlen);
            default:  prdata = 32'd0;
        endcase
    end

    assign o_cfg.hpat = r_hpat;
    assign o_cfg.hlen = clamp_len(r_hlen);
    assign o_cfg.tpat = r_tpat;
    assign o_cfg.tlen = clamp_len(r_tlen);

endmodule

`default_nettype wire

// ===== hdl/ring_buffer_frame_sync_core.sv =====
// push: acknowledged in the cycle after acceptance, only if burst_last is set
// pop: each delivered byte takes a ring memory read, then the output register
// sync: one held byte scanned per cycle from the ring memory
// throughput: one operation at a time; a new item is taken once the previous one is done
// reset (synchronous, active low) clears pointers, state and valid flags; ring contents stay
`default_nettype none

module ring_buffer_frame_sync_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rbfs_in_if.sink                    i_item,
    rbfs_out_if.source                 o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rbfs_pkg::*;

    localparam int SUM_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
    localparam int CW    = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    t_cfg cfg;

    rbfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [7:0] mem [DEPTH];

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] r_fill, n_fill;
    logic [PTR_W-1:0] r_n, n_n;
    logic [PTR_W-1:0] r_issue, n_issue;
    logic             r_rcv_valid, n_rcv_valid;
    logic [PTR_W-1:0] r_rcv_off, n_rcv_off;
    logic [WIN_W-1:0] r_win, n_win;
    logic [LEN_W-1:0] r_seen, n_seen;
    logic             r_trl, n_trl;
    logic [PTR_W-1:0] r_start, n_start;
    logic [PTR_W-1:0] r_stop, n_stop;
    t_sync            r_status, n_status;
    logic [7:0]       r_rd_data;

    logic             r_out_valid, n_out_valid;
    t_kind            r_out_kind, n_out_kind;
    logic [7:0]       r_out_byte, n_out_byte;
    logic [PTR_W-1:0] r_out_fill, n_out_fill;
    t_sync            r_out_status, n_out_status;
    logic [PTR_W-1:0] r_out_start, n_out_start;
    logic [PTR_W-1:0] r_out_stop, n_out_stop;
    logic             r_out_last, n_out_last;

    logic             slot_free;
    logic             accept;
    logic             mem_we;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] held;
    logic             short_data;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] cnt;
    logic             issue;
    logic [WIN_W-1:0] win_new;
    logic [LEN_W-1:0] seen_new;
    logic             found;

    assign slot_free    = !r_out_valid || o_res.ready;
    assign i_item.ready = (r_state == ST_IDLE) && slot_free;
    assign accept       = i_item.valid && i_item.ready;
    assign held         = r_wp - r_rp;
    assign short_data   = SUM_W'(held) < (SUM_W'(cfg.hlen) + SUM_W'(cfg.tlen));

    always_comb begin
        if (i_item.pop_limit == 7'd0) begin
            lim = CNT_W'(1);
        end else if (int'(i_item.pop_limit) > POP_MAX) begin
            lim = CNT_W'(POP_MAX);
        end else begin
            lim = CNT_W'(i_item.pop_limit);
        end
        cnt = (CW'(held) < CW'(lim)) ? CNT_W'(held) : lim;
    end

    assign issue    = r_issue != r_n;
    assign win_new  = (r_win << 8) | WIN_W'(r_rd_data);
    assign seen_new = (int'(r_seen) == MAX_PATTERN) ? r_seen : r_seen + LEN_W'(1);
    assign rd_addr  = (r_state == ST_SCAN) ? r_rp + r_issue : r_rp;

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_cnt        = r_cnt;
        n_fill       = r_fill;
        n_n          = r_n;
        n_issue      = r_issue;
        n_rcv_valid  = 1'b0;
        n_rcv_off    = r_rcv_off;
        n_win        = r_win;
        n_seen       = r_seen;
        n_trl        = r_trl;
        n_start      = r_start;
        n_stop       = r_stop;
        n_status     = r_status;
        mem_we       = 1'b0;
        found        = 1'b0;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_byte   = r_out_byte;
        n_out_fill   = r_out_fill;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_stop   = r_out_stop;
        n_out_last   = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_op'(i_item.opcode))
                        OP_PUSH: begin
                            mem_we = 1'b1;
                            n_wp   = r_wp + PTR_W'(1);
                            if (i_item.burst_last) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = RK_ACK;
                                n_out_byte   = 8'd0;
                                n_out_fill   = r_wp + PTR_W'(1) - r_rp;
                                n_out_status = SS_FOUND;
                                n_out_start  = '0;
                                n_out_stop   = '0;
                                n_out_last   = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (held == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = RK_EMPTY;
                                n_out_byte   = 8'd0;
                                n_out_fill   = '0;
                                n_out_status = SS_FOUND;
                                n_out_start  = '0;
                                n_out_stop   = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                n_cnt   = cnt;
                                n_fill  = PTR_W'(CW'(held) - CW'(cnt));
                                n_state = ST_POP_READ;
                            end
                        end
                        OP_SYNC: begin
                            if (short_data) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = RK_SYNC;
                                n_out_byte   = 8'd0;
                                n_out_fill   = held;
                                n_out_status = SS_SHORT;
                                n_out_start  = '0;
                                n_out_stop   = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                n_n     = held;
                                n_issue = '0;
                                n_seen  = '0;
                                n_trl   = 1'b0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP_READ: begin
                n_state = ST_POP_DATA;
            end
            ST_POP_DATA: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = RK_BYTE;
                    n_out_byte   = r_rd_data;
                    n_out_fill   = r_fill;
                    n_out_status = SS_FOUND;
                    n_out_start  = '0;
                    n_out_stop   = '0;
                    n_out_last   = (r_cnt == CNT_W'(1));
                    n_rp         = r_rp + PTR_W'(1);
                    n_cnt        = r_cnt - CNT_W'(1);
                    n_state      = (r_cnt == CNT_W'(1)) ? ST_IDLE : ST_POP_READ;
                end
            end
            ST_SCAN: begin
                n_issue     = r_issue + PTR_W'(issue);
                n_rcv_valid = issue;
                n_rcv_off   = r_issue;
                if (r_rcv_valid) begin
                    n_win  = win_new;
                    n_seen = seen_new;
                    if (!r_trl) begin
                        if (seen_new >= cfg.hlen && match_win(win_new, cfg.hpat, cfg.hlen)) begin
                            n_trl   = 1'b1;
                            n_seen  = '0;
                            n_start = r_rp + r_rcv_off - PTR_W'(cfg.hlen) + PTR_W'(1);
                        end
                    end else if (seen_new >= cfg.tlen
                                 && match_win(win_new, cfg.tpat, cfg.tlen)) begin
                        found    = 1'b1;
                        n_stop   = r_rp + r_rcv_off + PTR_W'(1);
                        n_status = SS_FOUND;
                        n_state  = ST_REPORT;
                    end
                    if (!found && r_rcv_off == r_n - PTR_W'(1)) begin
                        n_status = SS_NONE;
                        n_state  = ST_REPORT;
                    end
                end
            end
            ST_REPORT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = RK_SYNC;
                    n_out_byte   = 8'd0;
                    n_out_fill   = r_n;
                    n_out_status = r_status;
                    n_out_start  = (r_status == SS_FOUND) ? r_start : '0;
                    n_out_stop   = (r_status == SS_FOUND) ? r_stop : '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= i_item.data_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_rcv_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_rcv_valid <= n_rcv_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_fill       <= n_fill;
        r_n          <= n_n;
        r_issue      <= n_issue;
        r_rcv_off    <= n_rcv_off;
        r_win        <= n_win;
        r_seen       <= n_seen;
        r_trl        <= n_trl;
        r_start      <= n_start;
        r_stop       <= n_stop;
        r_status     <= n_status;
        r_out_kind   <= n_out_kind;
        r_out_byte   <= n_out_byte;
        r_out_fill   <= n_out_fill;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_stop   <= n_out_stop;
        r_out_last   <= n_out_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.byte_out    = r_out_byte;
    assign o_res.fill_level  = 8'(r_out_fill);
    assign o_res.sync_status = r_out_status;
    assign o_res.frame_start = 8'(r_out_start);
    assign o_res.frame_stop  = 8'(r_out_stop);
    assign o_res.last        = r_out_last;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_item.ready)
        else $error("item accepted while busy");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP_READ || r_state == ST_POP_DATA) |-> (r_cnt != '0))
        else $error("pop running with zero count");

    a_multi_only_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |-> (o_res.result_kind == RK_BYTE))
        else $error("non-final result that is not a popped byte");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= r_n))
        else $error("scan read beyond held data");
`endif

endmodule

`default_nettype wire

// ===== tb/ring_buffer_frame_sync_core_tb.sv =====
`timescale 1ns / 1ps

module ring_buffer_frame_sync_core_tb;
    import rbfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 20;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] fill;
        t_sync      status;
        logic [7:0] start;
        logic [7:0] stop;
        logic       last;
    } t_ring_result;

    class ring_scoreboard;
        logic [7:0]       ring [DEPTH];
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        logic [31:0]      hpat;
        logic [2:0]       hlen;
        logic [31:0]      tpat;
        logic [2:0]       tlen;
        t_ring_result     due_results[$];
        int               errors;
        int               n_items;
        int               n_results;
        int               n_found;
        int               n_wraps;
        int               n_reg_writes;

        function new();
            wr_ptr       = '0;
            rd_ptr       = '0;
            hpat         = 32'h24;
            hlen         = 3'd1;
            tpat         = 32'h0A;
            tlen         = 3'd1;
            errors       = 0;
            n_items      = 0;
            n_results    = 0;
            n_found      = 0;
            n_wraps      = 0;
            n_reg_writes = 0;
        endfunction

        function int held();
            logic [PTR_W-1:0] d;
            d = wr_ptr - rd_ptr;
            return int'(d);
        endfunction

        function int eff_len(logic [2:0] len);
            if (len == 3'd0) begin
                return 1;
            end
            if (int'(len) > MAX_PATTERN) begin
                return MAX_PATTERN;
            end
            return int'(len);
        endfunction

        function bit matches_at(int off, logic [31:0] pat, int len);
            logic [PTR_W-1:0] pos;
            for (int k = 0; k < len; k++) begin
                pos = rd_ptr + PTR_W'(off + k);
                if (ring[pos] != pat[8*k +: 8]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void add(t_kind kind, int data, int fill, t_sync status, int start, int stop,
                          bit last_flag);
            t_ring_result r;
            r.kind   = kind;
            r.data   = 8'(data);
            r.fill   = 8'(fill);
            r.status = status;
            r.start  = 8'(start);
            r.stop   = 8'(stop);
            r.last   = last_flag;
            due_results.push_back(r);
        endfunction

        function void set_reg(t_reg idx, logic [31:0] val);
            case (idx)
                REG_HPAT: hpat = val;
                REG_HLEN: hlen = val[2:0];
                REG_TPAT: tpat = val;
                REG_TLEN: tlen = val[2:0];
                default: ;
            endcase
            n_reg_writes++;
        endfunction

        function void apply_op(t_op op, logic [7:0] data, logic blast, logic [6:0] limit);
            int               n;
            int               cnt;
            int               lim;
            int               lh;
            int               lt;
            bit               done;
            bit               found;
            logic [PTR_W-1:0] fstart;
            logic [PTR_W-1:0] fstop;
            case (op)
                OP_PUSH: begin
                    ring[wr_ptr] = data;
                    wr_ptr = wr_ptr + 1'b1;
                    if (wr_ptr == rd_ptr) begin
                        n_wraps++;
                    end
                    if (blast) begin
                        add(RK_ACK, 0, held(), SS_FOUND, 0, 0, 1'b1);
                    end
                end
                OP_POP: begin
                    lim = (limit == 7'd0) ? 1 : ((int'(limit) > POP_MAX) ? POP_MAX : int'(limit));
                    n = held();
                    if (n == 0) begin
                        add(RK_EMPTY, 0, 0, SS_FOUND, 0, 0, 1'b1);
                    end else begin
                        cnt = (n < lim) ? n : lim;
                        for (int i = 0; i < cnt; i++) begin
                            add(RK_BYTE, ring[rd_ptr], n - cnt, SS_FOUND, 0, 0, i == cnt - 1);
                            rd_ptr = rd_ptr + 1'b1;
                        end
                    end
                end
                OP_SYNC: begin
                    n     = held();
                    lh    = eff_len(hlen);
                    lt    = eff_len(tlen);
                    done  = 1'b0;
                    found = 1'b0;
                    if (n < lh + lt) begin
                        add(RK_SYNC, 0, n, SS_SHORT, 0, 0, 1'b1);
                    end else begin
                        // only the first header decides the outcome
                        for (int i = 0; i + lh <= n && !done; i++) begin
                            if (matches_at(i, hpat, lh)) begin
                                done = 1'b1;
                                for (int j = i + lh; j + lt <= n && !found; j++) begin
                                    if (matches_at(j, tpat, lt)) begin
                                        found  = 1'b1;
                                        fstart = rd_ptr + PTR_W'(i);
                                        fstop  = rd_ptr + PTR_W'(j + lt);
                                    end
                                end
                            end
                        end
                        if (found) begin
                            n_found++;
                            add(RK_SYNC, 0, n, SS_FOUND, fstart, fstop, 1'b1);
                        end else begin
                            add(RK_SYNC, 0, n, SS_NONE, 0, 0, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
            if (op != OP_NONE) begin
                n_items++;
            end
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_ring_result got);
            t_ring_result want;
            if (due_results.size() == 0) begin
                $error("result with no expectation waiting: kind %0d", got.kind);
                errors++;
                return;
            end
            want = due_results.pop_front();
            n_results++;
            cmp("result_kind", want.kind, got.kind);
            cmp("byte_out", want.data, got.data);
            cmp("fill_level", want.fill, got.fill);
            cmp("sync_status", want.status, got.status);
            cmp("frame_start", want.start, got.start);
            cmp("frame_stop", want.stop, got.stop);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rbfs_in_if  item_if ();
    rbfs_out_if res_if ();

    ring_scoreboard sb;
    int             src_idle_pct;
    int             snk_idle_pct;
    int             rx_hold;
    int             quiet_cycles;

    ring_buffer_frame_sync_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin : rx_side
        t_ring_result got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.kind   = t_kind'(res_if.result_kind);
                got.data   = res_if.byte_out;
                got.fill   = res_if.fill_level;
                got.status = t_sync'(res_if.sync_status);
                got.start  = res_if.frame_start;
                got.stop   = res_if.frame_stop;
                got.last   = res_if.last;
                sb.check_result(got);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] data, input logic blast,
                             input logic [6:0] limit);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.opcode     <= op;
        item_if.data_byte  <= data;
        item_if.burst_last <= blast;
        item_if.pop_limit  <= limit;
        @(posedge i_clk);
        while (!item_if.ready) begin
            @(posedge i_clk);
        end
        sb.apply_op(op, data, blast, limit);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(input logic [31:0] hp, input logic [2:0] hl,
                                 input logic [31:0] tp, input logic [2:0] tl);
        write_reg(REG_HPAT, hp);
        write_reg(REG_HLEN, 32'(hl));
        write_reg(REG_TPAT, tp);
        write_reg(REG_TLEN, 32'(tl));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_items();
        // empty buffer, short data and the unused opcode
        send_item(OP_POP, 8'h5A, 1'b1, 7'd1);
        send_item(OP_SYNC, 8'hA5, 1'b0, 7'd0);
        send_item(OP_NONE, 8'hFF, 1'b1, 7'h7F);
        send_item(OP_PUSH, 8'h24, 1'b0, 7'h00);
        send_item(OP_SYNC, 8'h00, 1'b1, 7'h55);
        // header, body, trailer
        send_item(OP_PUSH, 8'h41, 1'b0, 7'h2A);
        send_item(OP_PUSH, 8'h0A, 1'b1, 7'h7F);
        send_item(OP_SYNC, 8'hFF, 1'b0, 7'h00);
        send_item(OP_PUSH, 8'h00, 1'b0, 7'h00);
        send_item(OP_PUSH, 8'hFF, 1'b1, 7'h7F);
        // pop limit zero, above range, then empty
        send_item(OP_POP, 8'h00, 1'b0, 7'd0);
        send_item(OP_POP, 8'hFF, 1'b1, 7'h7F);
        send_item(OP_POP, 8'h00, 1'b0, 7'd64);
        // trailer only ahead of header
        send_item(OP_PUSH, 8'h0A, 1'b1, 7'h01);
        send_item(OP_PUSH, 8'h24, 1'b1, 7'h40);
        send_item(OP_SYNC, 8'h12, 1'b1, 7'h3F);
        send_item(OP_POP, 8'h34, 1'b0, 7'd65);
        // no header at all
        send_item(OP_PUSH, 8'h0A, 1'b0, 7'h10);
        send_item(OP_PUSH, 8'h0B, 1'b1, 7'h20);
        send_item(OP_SYNC, 8'h56, 1'b0, 7'h00);
        send_item(OP_POP, 8'h78, 1'b1, 7'd64);
    endtask

    task automatic random_step();
        int         sel;
        int         lh;
        int         lt;
        bit         bad_head;
        bit         bad_tail;
        logic [7:0] b;
        sel = $urandom_range(99);
        lh  = sb.eff_len(sb.hlen);
        lt  = sb.eff_len(sb.tlen);
        if (sel < 55) begin
            bad_head = ($urandom_range(99) < 10);
            bad_tail = ($urandom_range(99) < 20);
            repeat ($urandom_range(3)) begin
                send_item(OP_PUSH, 8'($urandom), 1'($urandom_range(99) < 15), 7'($urandom));
            end
            for (int k = 0; k < lh; k++) begin
                b = sb.hpat[8*k +: 8];
                if (bad_head && k == 0) begin
                    b = ~b;
                end
                send_item(OP_PUSH, b, 1'b0, 7'($urandom));
            end
            repeat ($urandom_range(6)) begin
                send_item(OP_PUSH, 8'($urandom), 1'($urandom_range(99) < 15), 7'($urandom));
            end
            for (int k = 0; k < lt; k++) begin
                b = sb.tpat[8*k +: 8];
                if (bad_tail && k == lt - 1) begin
                    b = ~b;
                end
                send_item(OP_PUSH, b, k == lt - 1, 7'($urandom));
            end
            send_item(OP_SYNC, 8'($urandom), 1'($urandom), 7'($urandom));
            if ($urandom_range(1) == 1) begin
                send_item(OP_POP, 8'($urandom), 1'($urandom), 7'($urandom_range(127)));
            end
        end else if (sel < 73) begin
            if ($urandom_range(1) == 1) begin
                send_item(OP_POP, 8'($urandom), 1'($urandom), 7'($urandom_range(1, 12)));
            end else begin
                send_item(OP_POP, 8'($urandom), 1'($urandom), 7'($urandom_range(127)));
            end
        end else if (sel < 83) begin
            send_item(OP_SYNC, 8'($urandom), 1'($urandom), 7'($urandom));
        end else if (sel < 93) begin
            send_item(OP_PUSH, 8'($urandom), 1'($urandom), 7'($urandom));
        end else if (sel < 97) begin
            send_item(OP_NONE, 8'($urandom), 1'($urandom), 7'($urandom));
        end else begin
            drain();
        end
    endtask

    task automatic pressure_run();
        repeat (20) send_item(OP_PUSH, 8'($urandom), 1'b0, 7'($urandom));
        rx_hold = HOLD_CYCLES;
        repeat (6) begin
            send_item(OP_PUSH, 8'($urandom), 1'b1, 7'($urandom));
            send_item(OP_POP, 8'($urandom), 1'($urandom), 7'($urandom_range(1, 8)));
        end
        send_item(OP_SYNC, 8'($urandom), 1'($urandom), 7'($urandom));
    endtask

    initial begin
        logic [2:0]  hl_tab [6];
        logic [2:0]  tl_tab [6];
        logic [31:0] hp;
        logic [31:0] tp;
        int          phase_end;
        hl_tab = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd3};
        tl_tab = '{3'd7, 3'd1, 3'd0, 3'd4, 3'd3, 3'd2};
        sb = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        item_if.valid      = 1'b0;
        item_if.opcode     = OP_PUSH;
        item_if.data_byte  = '0;
        item_if.burst_last = 1'b0;
        item_if.pop_limit  = '0;
        res_if.ready       = 1'b0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        rx_hold            = 0;
        quiet_cycles       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            src_idle_pct = (ph < 2) ? 22 : ((ph < 4) ? 88 : 0);
            snk_idle_pct = (ph < 2) ? 88 : ((ph < 4) ? 22 : 0);
            hp = (ph == 1) ? 32'hFFFF_FFFF : ((ph == 2) ? 32'h0 : $urandom());
            tp = (ph == 1) ? 32'h0 : ((ph == 2) ? 32'hFFFF_FFFF : $urandom());
            load_settings(hp, hl_tab[ph], tp, tl_tab[ph]);
            if (ph == 4) begin
                pressure_run();
            end
            phase_end = sb.n_items + PHASE_ITEMS;
            while (sb.n_items < phase_end) begin
                random_step();
            end
        end
        drain();

        if (sb.due_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.due_results.size());
            sb.errors++;
        end
        $display("covered %0d operations and %0d checked results under %0d register writes",
                 sb.n_items, sb.n_results, sb.n_reg_writes);
        $display("frames located: %0d, full-buffer overwrites: %0d", sb.n_found, sb.n_wraps);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
